[src/deccc_pkg.sv]
package deccc_pkg;

	localparam int POS_WIDTH = 16;
	localparam int FIELD_W = 16;
	localparam int LEVEL_W = 8;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [LEVEL_W-1:0] GAIN_RESET = 8'd5;
	localparam logic signed [FIELD_W-1:0] START_X_RESET = 16'sd160;
	localparam logic signed [FIELD_W-1:0] START_Y_RESET = 16'sd120;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd255;

	localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
	localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic [LEVEL_W-1:0] level_t;

	typedef enum logic [1:0] {
		REG_STEP_GAIN,
		REG_START_X,
		REG_START_Y
	} reg_index_t;

	typedef struct packed {
		logic x_line_a;
		logic x_line_b;
		logic y_line_a;
		logic y_line_b;
		logic button_one;
		logic button_two;
	} sample_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] cursor_x;
		logic signed [FIELD_W-1:0] cursor_y;
		logic signed [FIELD_W-1:0] prev_x;
		logic signed [FIELD_W-1:0] prev_y;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
		logic draw_line;
		logic clear_screen;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] step_gain;
		logic signed [FIELD_W-1:0] start_x;
		logic signed [FIELD_W-1:0] start_y;
	} cfg_t;

	typedef struct packed {
		logic x;
		logic y;
	} pos_load_t;

	// Detent seen on one encoder: line A alone or line B alone after both together.
	typedef struct packed {
		logic a_alone;
		logic b_alone;
	} detent_t;

	// Position movement after saturation.
	typedef struct packed {
		logic up;
		logic down;
	} move_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} levels_t;

	function automatic pos_t pos_clamp_start(logic signed [FIELD_W-1:0] v);
		logic signed [32:0] v_ext;
		logic signed [32:0] max_ext;
		logic signed [32:0] min_ext;
		v_ext = 33'(v);
		max_ext = 33'(POS_MAX);
		min_ext = 33'(POS_MIN);
		if (v_ext > max_ext) begin
			return POS_MAX;
		end else if (v_ext < min_ext) begin
			return POS_MIN;
		end
		return POS_WIDTH'(v_ext);
	endfunction

	function automatic logic signed [FIELD_W-1:0] pos_field(pos_t p);
		logic signed [31:0] wide;
		wide = 32'(p);
		return wide[FIELD_W-1:0];
	endfunction

	function automatic pos_t pos_step(pos_t p, move_t m);
		if (m.up) begin
			return p + POS_WIDTH'(1);
		end else if (m.down) begin
			return p - POS_WIDTH'(1);
		end
		return p;
	endfunction

endpackage

[src/deccc_apb.sv]
module deccc_apb import deccc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg,
	output pos_load_t         load
);

	logic       wr_en;
	reg_index_t index;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign index = reg_index_t'(paddr[ADDR_W-1:2]);
	assign cfg = cfg_q;

	always_comb begin
		load = '0;
		if (wr_en) begin
			case (index)
				REG_START_X: load.x = 1'b1;
				REG_START_Y: load.y = 1'b1;
				default: load = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_gain <= GAIN_RESET;
			cfg_q.start_x <= START_X_RESET;
			cfg_q.start_y <= START_Y_RESET;
		end else if (wr_en) begin
			case (index)
				REG_STEP_GAIN: cfg_q.step_gain <= pwdata[LEVEL_W-1:0];
				REG_START_X: cfg_q.start_x <= pwdata[FIELD_W-1:0];
				REG_START_Y: cfg_q.start_y <= pwdata[FIELD_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_STEP_GAIN: prdata = DATA_W'(cfg_q.step_gain);
			REG_START_X: prdata = DATA_W'(cfg_q.start_x);
			REG_START_Y: prdata = DATA_W'(cfg_q.start_y);
			default: prdata = '0;
		endcase
	end

endmodule

[src/deccc_axis.sv]
module deccc_axis import deccc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    line_a,
	input  logic    line_b,
	output detent_t detent
);

	// Only the both-lines flag decides a detent; the single-line flags never gate it.
	logic both_seen_q;

	assign detent.a_alone = line_a && !line_b && both_seen_q;
	assign detent.b_alone = line_b && !line_a && both_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			both_seen_q <= 1'b0;
		end else if (advance) begin
			if (line_a && line_b) begin
				both_seen_q <= 1'b1;
			end else if (detent.a_alone || detent.b_alone) begin
				both_seen_q <= 1'b0;
			end
		end
	end

endmodule

[src/deccc_color.sv]
module deccc_color import deccc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  logic    button_one,
	input  logic    button_two,
	input  level_t  step_gain,
	input  move_t   x_move,
	input  move_t   y_move,
	output levels_t levels_next,
	output logic    draw_line,
	output logic    clear_screen
);

	levels_t levels_q;
	logic    x_moved;
	logic    y_moved;

	// An adjustment that would leave 0..255 is dropped.
	function automatic level_t adjust(level_t chan, level_t gain, logic neg);
		logic [LEVEL_W+1:0] sum;
		sum = neg ? ({2'b00, chan} - {2'b00, gain}) : ({2'b00, chan} + {2'b00, gain});
		return (sum[LEVEL_W+1:LEVEL_W] == 2'b00) ? sum[LEVEL_W-1:0] : chan;
	endfunction

	assign x_moved = x_move.up || x_move.down;
	assign y_moved = y_move.up || y_move.down;

	// Green follows the inverted Y change, so the cursor moving up lowers it.
	always_comb begin
		levels_next = levels_q;
		if (button_one && x_moved) begin
			levels_next.red = adjust(levels_q.red, step_gain, x_move.down);
		end else if (button_one && y_moved) begin
			levels_next.green = adjust(levels_q.green, step_gain, y_move.up);
		end else if (button_two && x_moved) begin
			levels_next.blue = adjust(levels_q.blue, step_gain, x_move.down);
		end
	end

	assign draw_line = !button_one && !button_two;
	assign clear_screen = button_one && button_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q.red <= LEVEL_RESET;
			levels_q.green <= LEVEL_RESET;
			levels_q.blue <= LEVEL_RESET;
		end else if (advance) begin
			levels_q <= levels_next;
		end
	end

endmodule

[src/dual_encoder_cursor_color_control.sv]
// Path: a transferred sample is held in the input register, then its result is
// registered in the result register once that is free or being taken.
// Throughput: one sample per cycle while the result side does not stall; the input
// register and the result register let a new sample in while the previous result still waits to be taken.
// Reset clears the detent flags and the valid bits, sets all colour channels to
// 255, the step gain to 5 and the cursor to the start position (160, 120).
module dual_encoder_cursor_color_control import deccc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	cfg_t      cfg;
	pos_load_t load;

	logic    valid_s1;
	sample_t sample_s1;
	logic    result_valid_q;
	result_t result_q;
	pos_t    pos_x_q;
	pos_t    pos_y_q;
	pos_t    pos_x_next;
	pos_t    pos_y_next;

	logic    advance;
	logic    accept;
	detent_t x_detent;
	detent_t y_detent;
	move_t   x_move;
	move_t   y_move;
	levels_t levels_next;
	logic    draw_line;
	logic    clear_screen;

	deccc_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.load    (load)
	);

	assign advance = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept = sample_valid && !sample_stall;

	deccc_axis u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.line_a  (sample_s1.x_line_a),
		.line_b  (sample_s1.x_line_b),
		.detent  (x_detent)
	);

	deccc_axis u_axis_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.line_a  (sample_s1.y_line_a),
		.line_b  (sample_s1.y_line_b),
		.detent  (y_detent)
	);

	// X: line A steps down, line B up. Y runs the other way round.
	// A detent at the limit still clears the flags but leaves the position.
	assign x_move.up = x_detent.b_alone && (pos_x_q != POS_MAX);
	assign x_move.down = x_detent.a_alone && (pos_x_q != POS_MIN);
	assign y_move.up = y_detent.a_alone && (pos_y_q != POS_MAX);
	assign y_move.down = y_detent.b_alone && (pos_y_q != POS_MIN);

	assign pos_x_next = pos_step(pos_x_q, x_move);
	assign pos_y_next = pos_step(pos_y_q, y_move);

	deccc_color u_color (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.button_one   (sample_s1.button_one),
		.button_two   (sample_s1.button_two),
		.step_gain    (cfg.step_gain),
		.x_move       (x_move),
		.y_move       (y_move),
		.levels_next  (levels_next),
		.draw_line    (draw_line),
		.clear_screen (clear_screen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= pos_clamp_start(START_X_RESET);
			pos_y_q <= pos_clamp_start(START_Y_RESET);
		end else begin
			if (load.x) begin
				pos_x_q <= pos_clamp_start(pwdata[FIELD_W-1:0]);
			end else if (advance) begin
				pos_x_q <= pos_x_next;
			end
			if (load.y) begin
				pos_y_q <= pos_clamp_start(pwdata[FIELD_W-1:0]);
			end else if (advance) begin
				pos_y_q <= pos_y_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			result_q.cursor_x <= pos_field(pos_x_next);
			result_q.cursor_y <= pos_field(pos_y_next);
			result_q.prev_x <= pos_field(pos_x_q);
			result_q.prev_y <= pos_field(pos_y_q);
			result_q.red_level <= levels_next.red;
			result_q.green_level <= levels_next.green;
			result_q.blue_level <= levels_next.blue;
			result_q.draw_line <= draw_line;
			result_q.clear_screen <= clear_screen;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

[sim/tb_top.sv]
module tb_top;
	import deccc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 4;
	// Line levels {a, b} for the four quadrature phases in forward order.
	localparam logic [1:0] QUAD_LEVELS [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	sample_t           sample = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;

	dual_encoder_cursor_color_control uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// Predicted block state.
	int   gain_now;
	int   cur_x;
	int   cur_y;
	logic x_saw_a, x_saw_b, x_saw_both;
	logic y_saw_a, y_saw_b, y_saw_both;
	int   red_lvl, green_lvl, blue_lvl;

	result_t expected_results[$];
	int      errors = 0;
	int      samples_sent = 0;
	int      results_seen = 0;
	int      cursor_moves = 0;
	int      colour_changes = 0;
	int      clear_requests = 0;
	int      cycle_count = 0;

	logic idle_on = 1'b1;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;
	int   stall_left = 0;
	int   phase_x = 0;
	int   phase_y = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Returns -1 for a line A detent, +1 for a line B detent, else 0.
	function automatic int detent_dir(input logic a, input logic b, inout logic saw_a,
		inout logic saw_b, inout logic saw_both);
		int dir;
		dir = 0;
		if (a) begin
			saw_a = 1'b1;
			if (b) saw_both = 1'b1;
			if (!b && saw_both) begin
				dir = -1;
				saw_a = 1'b0;
				saw_b = 1'b0;
				saw_both = 1'b0;
			end
		end
		if (b) begin
			saw_b = 1'b1;
			if (a) saw_both = 1'b1;
			if (!a && saw_both) begin
				dir = 1;
				saw_a = 1'b0;
				saw_b = 1'b0;
				saw_both = 1'b0;
			end
		end
		return dir;
	endfunction

	function automatic int clamp_pos(int v);
		if (v > int'(POS_MAX)) return int'(POS_MAX);
		if (v < int'(POS_MIN)) return int'(POS_MIN);
		return v;
	endfunction

	function automatic void nudge_level(inout int lvl, input int delta);
		if (lvl + delta >= 0 && lvl + delta <= 255) begin
			lvl = lvl + delta;
			colour_changes++;
		end
	endfunction

	function automatic result_t predict_tick(sample_t s);
		result_t r;
		int old_x, old_y, dx, dy;
		logic draw;
		old_x = cur_x;
		old_y = cur_y;
		cur_x = clamp_pos(cur_x + detent_dir(s.x_line_a, s.x_line_b, x_saw_a, x_saw_b,
			x_saw_both));
		cur_y = clamp_pos(cur_y - detent_dir(s.y_line_a, s.y_line_b, y_saw_a, y_saw_b,
			y_saw_both));
		if (cur_x != old_x || cur_y != old_y) cursor_moves++;
		dx = (cur_x - old_x) * gain_now;
		dy = -(cur_y - old_y) * gain_now;
		draw = 1'b0;
		if (s.button_one && dx != 0) begin
			nudge_level(red_lvl, dx);
		end else if (s.button_one && dy != 0) begin
			nudge_level(green_lvl, dy);
		end else if (s.button_two && dx != 0) begin
			nudge_level(blue_lvl, dx);
		end else if (!s.button_one && !s.button_two) begin
			draw = 1'b1;
		end
		if (s.button_one && s.button_two) clear_requests++;
		r.cursor_x = FIELD_W'(cur_x);
		r.cursor_y = FIELD_W'(cur_y);
		r.prev_x = FIELD_W'(old_x);
		r.prev_y = FIELD_W'(old_y);
		r.red_level = LEVEL_W'(red_lvl);
		r.green_level = LEVEL_W'(green_lvl);
		r.blue_level = LEVEL_W'(blue_lvl);
		r.draw_line = draw;
		r.clear_screen = s.button_one & s.button_two;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t result transfer with nothing expected: expected none, got %p",
					$time, result);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("cursor_x", want.cursor_x, result.cursor_x);
				check_field("cursor_y", want.cursor_y, result.cursor_y);
				check_field("prev_x", want.prev_x, result.prev_x);
				check_field("prev_y", want.prev_y, result.prev_y);
				check_field("red_level", want.red_level, result.red_level);
				check_field("green_level", want.green_level, result.green_level);
				check_field("blue_level", want.blue_level, result.blue_level);
				check_field("draw_line", want.draw_line, result.draw_line);
				check_field("clear_screen", want.clear_screen, result.clear_screen);
			end
		end
	end

	// The long hold is taken once on request; otherwise stalls come in short bursts.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 10);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic send_sample(sample_t s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		expected_results.push_back(predict_tick(s));
		samples_sent++;
	endtask

	// Bundles line levels {a, b} for X and Y and the buttons {one, two}.
	function automatic sample_t tick(logic [1:0] x, logic [1:0] y, logic [1:0] buttons);
		return sample_t'({x, y, buttons});
	endfunction

	// Moves one encoder through its phases, now and then with random levels as noise.
	function automatic logic [1:0] walk_levels(inout int phase);
		int r;
		r = $urandom_range(0, 9);
		if (r >= 4 && r <= 6) phase = (phase + 1) % 4;
		else if (r >= 7 && r <= 8) phase = (phase + 3) % 4;
		if (r == 9) return 2'($urandom);
		return QUAD_LEVELS[phase];
	endfunction

	task automatic drain;
		sample_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(reg_index_t idx, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_STEP_GAIN: begin
				gain_now = int'(data[LEVEL_W-1:0]);
			end
			REG_START_X: begin
				cur_x = clamp_pos(int'($signed(data[FIELD_W-1:0])));
			end
			REG_START_Y: begin
				cur_y = clamp_pos(int'($signed(data[FIELD_W-1:0])));
			end
			default: begin
			end
		endcase
	endtask

	// Upper data bits are random: the block keeps only the register's own width.
	task automatic configure(int gain, int sx, int sy);
		drain();
		apb_write(REG_STEP_GAIN, {24'($urandom), 8'(gain)});
		apb_write(REG_START_X, {16'($urandom), 16'(sx)});
		apb_write(REG_START_Y, {16'($urandom), 16'(sy)});
	endtask

	task automatic run_walk(int count);
		sample_t s;
		repeat (count) begin
			s = tick(walk_levels(phase_x), walk_levels(phase_y), 2'($urandom));
			send_sample(s);
		end
	endtask

	task automatic test_detents;
		send_sample(tick(2'b00, 2'b00, 2'b00));
		send_sample(tick(2'b11, 2'b11, 2'b00));
		send_sample(tick(2'b01, 2'b10, 2'b00));
		send_sample(tick(2'b11, 2'b11, 2'b00));
		send_sample(tick(2'b10, 2'b01, 2'b00));
		// Both lines, then none: no detent, the flags stay set.
		send_sample(tick(2'b11, 2'b11, 2'b00));
		send_sample(tick(2'b00, 2'b00, 2'b00));
	endtask

	task automatic test_colour_select;
		// X and Y step together with button one held; red takes priority.
		send_sample(tick(2'b10, 2'b01, 2'b10));
		send_sample(tick(2'b11, 2'b11, 2'b10));
		send_sample(tick(2'b00, 2'b10, 2'b10));
		// Blue is already at the top, so this increase is skipped.
		send_sample(tick(2'b11, 2'b00, 2'b01));
		send_sample(tick(2'b01, 2'b00, 2'b01));
		send_sample(tick(2'b11, 2'b00, 2'b01));
		send_sample(tick(2'b10, 2'b00, 2'b01));
		// Button two with a Y step only changes nothing.
		send_sample(tick(2'b00, 2'b11, 2'b01));
		send_sample(tick(2'b00, 2'b01, 2'b01));
		send_sample(tick(2'b11, 2'b11, 2'b11));
		send_sample(tick(2'b01, 2'b10, 2'b11));
	endtask

	task automatic test_position_limits;
		configure(255, int'(POS_MAX), int'(POS_MIN));
		send_sample(tick(2'b11, 2'b11, 2'b00));
		send_sample(tick(2'b01, 2'b01, 2'b10));
		// The detent at the limit cleared the flags, so this one is not a step.
		send_sample(tick(2'b01, 2'b01, 2'b00));
		configure(0, int'(POS_MIN), int'(POS_MAX));
		send_sample(tick(2'b11, 2'b11, 2'b11));
		send_sample(tick(2'b10, 2'b10, 2'b11));
	endtask

	task automatic test_random_walk;
		configure($urandom_range(1, 9), $urandom_range(0, 400) - 200,
			$urandom_range(0, 400) - 200);
		run_walk(150);
	endtask

	task automatic test_gain_extremes;
		configure(0, int'(POS_MAX) - 2, int'(POS_MIN) + 2);
		run_walk(100);
		configure(255, int'(POS_MIN) + 2, int'(POS_MAX) - 2);
		run_walk(100);
	endtask

	task automatic test_backpressure;
		configure(5, 0, 0);
		hold_req <= 1'b1;
		run_walk(100);
	endtask

	task automatic test_steady_stream;
		configure($urandom_range(0, 255), int'($signed(16'($urandom))),
			int'($signed(16'($urandom))));
		idle_on <= 1'b0;
		run_walk(150);
	endtask

	initial begin
		gain_now = int'(GAIN_RESET);
		cur_x = clamp_pos(int'(START_X_RESET));
		cur_y = clamp_pos(int'(START_Y_RESET));
		{x_saw_a, x_saw_b, x_saw_both, y_saw_a, y_saw_b, y_saw_both} = '0;
		red_lvl = int'(LEVEL_RESET);
		green_lvl = int'(LEVEL_RESET);
		blue_lvl = int'(LEVEL_RESET);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_detents();
		test_colour_select();
		test_position_limits();
		test_random_walk();
		test_gain_extremes();
		test_backpressure();
		test_steady_stream();
		drain();

		$display("summary: %0d samples and %0d results checked, %0d cursor moves,",
			samples_sent, results_seen, cursor_moves);
		$display("summary: %0d colour changes, %0d clear requests, %0d errors",
			colour_changes, clear_requests, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[filelist.f]
src/deccc_pkg.sv
src/deccc_apb.sv
src/deccc_axis.sv
src/deccc_color.sv
src/dual_encoder_cursor_color_control.sv
sim/tb_top.sv
